// ===== rtl/ptne_pkg.sv =====
// Shared widths, codes and word types of the pitch-to-note event gate.
package ptne_pkg;

   localparam int NOTE_W      = 7;
   localparam int NOTE_COUNT  = 128;
   localparam int OFFSET_W    = 12;
   localparam int LEN_W       = 13;
   localparam int RMS_W       = 16;
   localparam int VEL_W       = 7;
   localparam int POS_W       = 48;
   localparam int SIL_W       = 32;
   localparam int MNS_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_BLOCK   = 4096;
   localparam int VEL_MAX     = 127;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MNS_W-1:0] MNS_RESET = MNS_W'(48);
   localparam logic [VEL_W-1:0] MINV_RESET = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_NOTE_SAMPLES = 2'd0,
      CSR_MIN_VELOCITY     = 2'd1
   } csr_index_type;

   // One accepted word, with the block position work already done.
   typedef struct packed {
      logic                detected;
      logic [NOTE_W-1:0]   note;
      logic [OFFSET_W-1:0] doff;
      logic [OFFSET_W-1:0] end_off;
      logic [LEN_W-1:0]    len;
      logic [RMS_W-1:0]    rms;
      logic [POS_W-1:0]    det_pos;
   } item_type;

   typedef struct packed {
      logic                is_note_on;
      logic [NOTE_W-1:0]   event_note;
      logic [VEL_W-1:0]    velocity;
      logic [OFFSET_W-1:0] event_offset;
   } result_type;

   typedef struct packed {
      logic on_requested;
      logic off_owed;
   } flag_type;

   typedef struct packed {
      logic              en;
      logic [NOTE_W-1:0] addr;
      flag_type          data;
   } mem_wr_type;

endpackage

// ===== rtl/ptne_if.sv =====
// Handshake channels of the pitch-to-note event gate: block summaries in, note events out.
interface ptne_req_if import ptne_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                detected;
   logic [NOTE_W-1:0]   note_number;
   logic [OFFSET_W-1:0] detect_offset;
   logic [LEN_W-1:0]    block_length;
   logic [RMS_W-1:0]    rms_level;

   modport source (output valid, detected, note_number, detect_offset, block_length,
                   rms_level, input ready);
   modport sink (input valid, detected, note_number, detect_offset, block_length,
                 rms_level, output ready);
endinterface

interface ptne_rsp_if import ptne_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                is_note_on;
   logic [NOTE_W-1:0]   event_note;
   logic [VEL_W-1:0]    velocity;
   logic [OFFSET_W-1:0] event_offset;

   modport source (output valid, is_note_on, event_note, velocity, event_offset,
                   input ready);
   modport sink (input valid, is_note_on, event_note, velocity, event_offset,
                 output ready);
endinterface

// ===== rtl/ptne_flag_mem.sv =====
// Per-note flag memory: one write and one registered read per cycle, write-first on collision.
module ptne_flag_mem import ptne_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [NOTE_W-1:0] rd_addr,
   input  mem_wr_type        mem_wr,
   output flag_type          rd_data
);

   flag_type                flag_mem_ff [NOTE_COUNT];
   logic [NOTE_COUNT-1:0]   written_ff;
   flag_type                rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         flag_mem_ff[mem_wr.addr] <= mem_wr.data;
      end
   end

   // An entry never written since reset reads as cleared.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mem_wr.en) begin
         written_ff[mem_wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en && (mem_wr.addr == rd_addr)) begin
         rd_data_ff <= mem_wr.data;
      end else if (written_ff[rd_addr]) begin
         rd_data_ff <= flag_mem_ff[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ptne_decide.sv =====
// Decision stage: tracks the active note and silence, updates note flags and forms the event.
module ptne_decide import ptne_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              s2_valid,
   input  item_type          s2_item,
   input  logic [MNS_W-1:0]  min_note_samples,
   input  logic [VEL_W-1:0]  min_velocity,
   input  flag_type          rd_flags,
   output mem_wr_type        mem_wr,
   output logic [NOTE_W-1:0] next_note,
   output logic              res_valid,
   output result_type        res
);

   logic              active_valid_ff, active_valid_in;
   logic [NOTE_W-1:0] active_note_ff, active_note_in;
   logic [POS_W-1:0]  note_start_ff, note_start_in;
   logic [SIL_W-1:0]  silence_ff, silence_in;

   logic [SIL_W:0]    sil_sum;
   logic [SIL_W-1:0]  sil_sat;
   logic [POS_W-1:0]  hold_diff;
   logic              long_enough;
   logic [RMS_W+6:0]  rms_prod;
   logic [7:0]        vel_raw;
   logic [VEL_W-1:0]  vel_sat;
   logic [VEL_W-1:0]  vel;

   always_comb begin
      sil_sum = {1'b0, silence_ff} + {(SIL_W + 1 - LEN_W)'(0), s2_item.len};
      sil_sat = sil_sum[SIL_W] ? '1 : sil_sum[SIL_W-1:0];

      // Hold time is taken modulo the position width and read as signed.
      hold_diff   = s2_item.det_pos - note_start_ff;
      long_enough = !hold_diff[POS_W-1] &&
                    (hold_diff > {(POS_W - MNS_W)'(0), min_note_samples});

      // rms * 127 in Q1.15, floored, then limited to min_velocity..127.
      rms_prod = {s2_item.rms, 7'b0} - {7'b0, s2_item.rms};
      vel_raw  = rms_prod[RMS_W+6:RMS_W-1];
      vel_sat  = (vel_raw > 8'(VEL_MAX)) ? VEL_W'(VEL_MAX) : vel_raw[VEL_W-1:0];
      vel      = (vel_sat < min_velocity) ? min_velocity : vel_sat;
   end

   always_comb begin
      active_valid_in = active_valid_ff;
      active_note_in  = active_note_ff;
      note_start_in   = note_start_ff;
      silence_in      = silence_ff;
      mem_wr          = '0;
      mem_wr.addr     = active_note_ff;
      res_valid       = 1'b0;
      res             = '0;
      if (s2_valid) begin
         if (!s2_item.detected) begin
            silence_in = sil_sat;
            if ((sil_sat > {(SIL_W - MNS_W)'(0), min_note_samples}) && active_valid_ff) begin
               mem_wr.en       = 1'b1;
               active_valid_in = 1'b0;
               if (rd_flags.off_owed) begin
                  res_valid        = 1'b1;
                  res.event_note   = active_note_ff;
                  res.event_offset = s2_item.end_off;
               end
            end
         end else begin
            silence_in = '0;
            if (!active_valid_ff) begin
               // Note zero after silence keeps the old start time.
               if (s2_item.note != '0) begin
                  note_start_in = s2_item.det_pos;
               end
            end else if (s2_item.note != active_note_ff) begin
               mem_wr.en     = 1'b1;
               note_start_in = s2_item.det_pos;
               if (rd_flags.off_owed) begin
                  res_valid        = 1'b1;
                  res.event_note   = active_note_ff;
                  res.event_offset = s2_item.doff;
               end
            end else if (long_enough && !rd_flags.on_requested) begin
               mem_wr.en                = 1'b1;
               mem_wr.data.on_requested = 1'b1;
               mem_wr.data.off_owed     = 1'b1;
               res_valid                = 1'b1;
               res.is_note_on           = 1'b1;
               res.event_note           = s2_item.note;
               res.velocity             = vel;
               res.event_offset         = s2_item.doff;
            end
            active_valid_in = 1'b1;
            active_note_in  = s2_item.note;
         end
      end
   end

   assign next_note = active_note_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_valid_ff <= 1'b0;
         active_note_ff  <= '0;
         note_start_ff   <= '0;
         silence_ff      <= '0;
      end else begin
         active_valid_ff <= active_valid_in;
         active_note_ff  <= active_note_in;
         note_start_ff   <= note_start_in;
         silence_ff      <= silence_in;
      end
   end

endmodule

// ===== rtl/ptne_rsp_queue.sv =====
// Small output queue that decouples the decision stage from the result receiver.
module ptne_rsp_queue import ptne_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  result_type        push_data,
   output logic [QCNT_W-1:0] count,
   ptne_rsp_if.source        rsp
);

   result_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;
   result_type          head;

   assign pop  = rsp.valid && rsp.ready;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign count            = count_ff;
   assign rsp.valid        = (count_ff != '0);
   assign rsp.is_note_on   = head.is_note_on;
   assign rsp.event_note   = head.event_note;
   assign rsp.velocity     = head.velocity;
   assign rsp.event_offset = head.event_offset;

endmodule

// ===== rtl/pitch_to_note_event_gate_core.sv =====
// Top level of the pitch-to-note event gate: accept stage, flag memory, decision and output queue.
//
// The block takes one summary word per audio block on req_bus (detected flag, note number,
// detection offset, block length, RMS level) and gives at most one note event per word on
// rsp_bus (note-on or note-off, note, velocity, sample offset within the block).
// Settings are written on the csr_ port: index 0 is the minimum hold or silence length in
// samples, index 1 the minimum note-on velocity. Write them only while no word is in flight.
// A word accepted at one clock edge is decided in the next cycle; its event, if any, is
// pushed into the output queue and offered on rsp_bus in the cycle after that. While the
// output queue has room, one word per cycle is sustained: the per-note flags sit in a
// 128-entry memory read for the note that becomes active and written back by the decision
// stage, with the read taking the written value when both hit the same note.
// Synchronous reset clears the sample position, the active note, the silence count and all
// note flags at once; there is no clearing pass and the block is ready as soon as
// reset falls. Events wait in a four-word queue while the receiver stalls; req_bus.ready
// falls only when that queue plus the word under decision would fill it, so no event is lost.
module pitch_to_note_event_gate_core import ptne_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ptne_req_if.sink              req_bus,
   ptne_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MNS_W-1:0]  min_note_samples_ff;
   logic [VEL_W-1:0]  min_velocity_ff;
   logic [POS_W-1:0]  position_ff;
   logic              s2_valid_ff;
   item_type          s2_item_ff, s2_item_in;
   logic              accept;
   logic [LEN_W-1:0]  len_clamped;
   logic [LEN_W-1:0]  len_minus_one;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W:0]   q_load;
   logic [NOTE_W-1:0] next_note;
   flag_type          rd_flags;
   mem_wr_type        mem_wr;
   logic              res_valid;
   result_type        res;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_note_samples_ff <= MNS_RESET;
         min_velocity_ff     <= MINV_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_NOTE_SAMPLES: min_note_samples_ff <= csr_wdata[MNS_W-1:0];
            CSR_MIN_VELOCITY:     min_velocity_ff     <= csr_wdata[VEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Count the queue and the word under decision so that every event has a slot.
   assign q_load        = {1'b0, q_count} + {QCNT_W'(0), s2_valid_ff};
   assign req_bus.ready = !reset && (q_load < (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      len_clamped = req_bus.block_length;
      if ({(32 - LEN_W)'(0), req_bus.block_length} > 32'(MAX_BLOCK)) begin
         len_clamped = LEN_W'(MAX_BLOCK);
      end
      len_minus_one = len_clamped - LEN_W'(1);

      s2_item_in.detected = req_bus.detected;
      s2_item_in.note     = req_bus.note_number;
      s2_item_in.doff     = req_bus.detect_offset;
      s2_item_in.len      = len_clamped;
      s2_item_in.rms      = req_bus.rms_level;
      s2_item_in.det_pos  = position_ff + {(POS_W - OFFSET_W)'(0), req_bus.detect_offset};
      if (len_clamped == '0) begin
         s2_item_in.end_off = '0;
      end else if (len_minus_one > {(LEN_W - OFFSET_W)'(0), {OFFSET_W{1'b1}}}) begin
         s2_item_in.end_off = '1;
      end else begin
         s2_item_in.end_off = len_minus_one[OFFSET_W-1:0];
      end
   end

   // The block position does not depend on any decision, so it advances at acceptance.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= accept;
         if (accept) begin
            position_ff <= position_ff + {(POS_W - LEN_W)'(0), len_clamped};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_item_ff <= s2_item_in;
      end
   end

   ptne_flag_mem u_flag_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (next_note),
      .mem_wr  (mem_wr),
      .rd_data (rd_flags)
   );

   ptne_decide u_decide (
      .clock            (clock),
      .reset            (reset),
      .s2_valid         (s2_valid_ff),
      .s2_item          (s2_item_ff),
      .min_note_samples (min_note_samples_ff),
      .min_velocity     (min_velocity_ff),
      .rd_flags         (rd_flags),
      .mem_wr           (mem_wr),
      .next_note        (next_note),
      .res_valid        (res_valid),
      .res              (res)
   );

   ptne_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .count     (q_count),
      .rsp       (rsp_bus)
   );

   // The queue and the word under decision never exceed the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      q_load <= (QCNT_W + 1)'(QUEUE_DEPTH))
      else $error("output queue can overflow");

   // Events and flag writes come only from a word under decision.
   assert property (@(posedge clock) disable iff (reset)
      (res_valid || mem_wr.en) |-> s2_valid_ff)
      else $error("event or flag write without a word");

   // A note-off always comes with a write that clears the flags of the note it ends.
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && res_valid && !res.is_note_on) |-> mem_wr.en)
      else $error("note-off without clearing the note flags");

   // A note-off carries no velocity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.is_note_on) |-> (rsp_bus.velocity == '0))
      else $error("note-off with nonzero velocity");

endmodule

// ===== verif/ptne_event_checker.sv =====
// Watches the block summary and note event channels, predicts each event and compares it.
module ptne_event_checker import ptne_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ptne_req_if                   req_mon,
   ptne_rsp_if                   rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           pending_count,
   output int unsigned           note_on_count,
   output int unsigned           note_off_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RMS_FRAC = 15;
   localparam int PROD_W   = RMS_W + VEL_W;

   logic [MNS_W-1:0] hold_min;
   logic [VEL_W-1:0] vel_floor;
   logic [POS_W-1:0] block_pos;
   logic [POS_W-1:0] note_start;
   logic             tracking;
   logic [NOTE_W-1:0] tracked_note;
   logic [SIL_W-1:0] quiet_len;
   logic             on_sent [NOTE_COUNT];
   logic             off_due [NOTE_COUNT];
   result_type       due_events[$];

   // Advances the gate state by one block summary; returns 1 when an event is due.
   function automatic logic judge_block(input logic det, input logic [NOTE_W-1:0] note,
                                        input logic [OFFSET_W-1:0] doff,
                                        input logic [LEN_W-1:0] len_in,
                                        input logic [RMS_W-1:0] rms, output result_type ev);
      logic [LEN_W-1:0]    len;
      logic [POS_W-1:0]    det_pos;
      logic [POS_W-1:0]    held;
      logic [SIL_W:0]      quiet_sum;
      logic [OFFSET_W-1:0] end_off;
      logic [PROD_W-1:0]   scaled;
      logic [VEL_W:0]      vel;
      logic                fired;
      fired = 1'b0;
      ev = '0;
      len = (len_in > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : len_in;
      if (!det) begin
         quiet_sum = {1'b0, quiet_len} + (SIL_W + 1)'(len);
         quiet_len = quiet_sum[SIL_W] ? '1 : quiet_sum[SIL_W-1:0];
         if (quiet_len > SIL_W'(hold_min) && tracking) begin
            // The note-off lands on the last sample of the silent block.
            end_off = (len == '0) ? '0 : OFFSET_W'(len - 1'b1);
            on_sent[tracked_note] = 1'b0;
            tracking = 1'b0;
            if (off_due[tracked_note]) begin
               off_due[tracked_note] = 1'b0;
               ev = '{1'b0, tracked_note, VEL_W'(0), end_off};
               fired = 1'b1;
            end
         end
      end else begin
         det_pos = block_pos + POS_W'(doff);
         quiet_len = '0;
         if (!tracking) begin
            // Note zero picks up tracking but keeps the old start position.
            if (note != '0) begin
               note_start = det_pos;
            end
         end else if (note != tracked_note) begin
            on_sent[tracked_note] = 1'b0;
            note_start = det_pos;
            if (off_due[tracked_note]) begin
               off_due[tracked_note] = 1'b0;
               ev = '{1'b0, tracked_note, VEL_W'(0), doff};
               fired = 1'b1;
            end
         end else begin
            // The hold time is read as a signed distance, so a detection earlier
            // than the recorded start never counts as held.
            held = det_pos - note_start;
            if (!held[POS_W-1] && held > POS_W'(hold_min) && !on_sent[note]) begin
               scaled = PROD_W'(rms) * PROD_W'(VEL_MAX);
               vel = scaled[PROD_W-1:RMS_FRAC];
               if (vel > VEL_MAX) begin
                  vel = (VEL_W + 1)'(VEL_MAX);
               end
               if (vel < {1'b0, vel_floor}) begin
                  vel = {1'b0, vel_floor};
               end
               on_sent[note] = 1'b1;
               off_due[note] = 1'b1;
               ev = '{1'b1, note, vel[VEL_W-1:0], doff};
               fired = 1'b1;
            end
         end
         tracking = 1'b1;
         tracked_note = note;
      end
      block_pos = block_pos + POS_W'(len);
      return fired;
   endfunction

   task automatic report_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
      if (want_v != got_v) begin
         mismatch_count++;
         $display("%0t: event field %s expected %0d, got %0d", $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      result_type fresh;
      logic       fired;
      if (reset) begin
         hold_min = MNS_RESET;
         vel_floor = MINV_RESET;
         block_pos = '0;
         note_start = '0;
         tracking = 1'b0;
         tracked_note = '0;
         quiet_len = '0;
         for (int i = 0; i < NOTE_COUNT; i++) begin
            on_sent[i] = 1'b0;
            off_due[i] = 1'b0;
         end
         due_events.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.is_note_on, rsp_mon.event_note, rsp_mon.velocity,
                    rsp_mon.event_offset};
            if (got.is_note_on) begin
               note_on_count++;
            end else begin
               note_off_count++;
            end
            if (due_events.size() == 0) begin
               mismatch_count++;
               $display("%0t: event with none expected: on=%0d note=%0d vel=%0d offset=%0d",
                        $time, got.is_note_on, got.event_note, got.velocity,
                        got.event_offset);
            end else begin
               want = due_events.pop_front();
               report_field("is_note_on", want.is_note_on, got.is_note_on);
               report_field("event_note", want.event_note, got.event_note);
               report_field("velocity", want.velocity, got.velocity);
               report_field("event_offset", want.event_offset, got.event_offset);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_NOTE_SAMPLES: begin
                  hold_min = csr_wdata[MNS_W-1:0];
               end
               CSR_MIN_VELOCITY: begin
                  vel_floor = csr_wdata[VEL_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            fired = judge_block(req_mon.detected, req_mon.note_number, req_mon.detect_offset,
                                req_mon.block_length, req_mon.rms_level, fresh);
            if (fired) begin
               due_events.insert(due_events.size(), fresh);
            end
         end
      end
      pending_count = due_events.size();
   end

endmodule

// ===== verif/tb_pitch_to_note_event_gate_core.sv =====
// Testbench top: drives block summaries and settings into the event gate and gives the verdict.
module tb_pitch_to_note_event_gate_core import ptne_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT    = 1_000_000;
   localparam int unsigned PHASE_WORDS    = 385;
   localparam int unsigned PHASE_COUNT    = 5;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned SQUEEZE_CYCLES = 200;
   localparam int unsigned SQUEEZE_WORDS  = 150;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned note_on_count;
   int unsigned note_off_count;

   int unsigned cycle_count;
   int unsigned words_sent;
   int unsigned settings_used;
   int unsigned hold_now;
   int unsigned steady_words;
   logic        calm_send;
   int unsigned squeeze_ask;
   int unsigned squeeze_done;
   int unsigned stall_left;
   int unsigned recv_cycles;
   logic        calm_recv;

   ptne_req_if req_bus ();
   ptne_rsp_if rsp_bus ();

   pitch_to_note_event_gate_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ptne_event_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .note_on_count  (note_on_count),
      .note_off_count (note_off_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Run stopped after %0d cycles without draining.", cycle_count);
      $display("pitch_to_note_event_gate_core: mismatch");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Receiver side: random stalls, calm stretches, and one long hold-off on request.
   always @(negedge clock) begin
      recv_cycles++;
      if (recv_cycles % 600 == 0) begin
         calm_recv = ($urandom_range(0, 2) == 0);
      end
      if (squeeze_ask != squeeze_done) begin
         stall_left = SQUEEZE_CYCLES;
         squeeze_done = squeeze_ask;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!calm_recv && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap();
         end
      end
   end

   function automatic logic [LEN_W-1:0] pick_len();
      if ($urandom_range(0, 19) == 0) begin
         return LEN_W'($urandom_range(0, 8191));
      end else if (hold_now > 2000) begin
         return LEN_W'($urandom_range(1024, MAX_BLOCK));
      end
      return LEN_W'($urandom_range(1, 256));
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_offset(input logic [LEN_W-1:0] len);
      int unsigned top;
      top = (len == '0) ? 0 : ((len > LEN_W'(MAX_BLOCK)) ? MAX_BLOCK - 1 : len - 1);
      if ($urandom_range(0, 6) == 0) begin
         return OFFSET_W'($urandom_range(0, 4095));
      end
      return OFFSET_W'($urandom_range(0, top));
   endfunction

   // Offers one word and returns at the edge where it is taken.
   task automatic offer(input logic det, input logic [NOTE_W-1:0] note,
                        input logic [OFFSET_W-1:0] doff, input logic [LEN_W-1:0] len,
                        input logic [RMS_W-1:0] rms);
      int unsigned gap;
      gap = (steady_words != 0 || calm_send) ? 0 : pick_gap();
      if (steady_words != 0) begin
         steady_words--;
      end
      if (gap != 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.detected <= det;
      req_bus.note_number <= note;
      req_bus.detect_offset <= doff;
      req_bus.block_length <= len;
      req_bus.rms_level <= rms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic offer_noise();
      offer(1'($urandom_range(0, 1)), NOTE_W'($urandom_range(0, 127)),
            OFFSET_W'($urandom_range(0, 4095)), LEN_W'($urandom_range(0, 8191)),
            RMS_W'($urandom_range(0, 65535)));
   endtask

   // A held note with random content, then silence, a note change or a stray word.
   task automatic play_phrase();
      logic [NOTE_W-1:0] note;
      logic [LEN_W-1:0]  len;
      int unsigned       need;
      int unsigned       holds;
      int unsigned       rests;
      int unsigned       r;
      note = ($urandom_range(0, 15) == 0) ? '0 : NOTE_W'($urandom_range(0, 127));
      need = 1 + hold_now / ((hold_now > 2000) ? 2560 : 128);
      holds = $urandom_range(1, need + 4);
      calm_send = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < holds; k++) begin
         len = pick_len();
         if ($urandom_range(0, 11) == 0) begin
            offer(1'b1, note ^ NOTE_W'($urandom_range(1, 127)), pick_offset(len), len,
                  RMS_W'($urandom_range(0, 65535)));
         end else begin
            offer(1'b1, note, pick_offset(len), len, RMS_W'($urandom_range(0, 65535)));
         end
      end
      r = $urandom_range(0, 9);
      if (r < 6) begin
         rests = $urandom_range(1, need + 3);
         for (int k = 0; k < rests; k++) begin
            len = pick_len();
            offer(1'b0, NOTE_W'($urandom_range(0, 127)), pick_offset(len), len,
                  RMS_W'($urandom_range(0, 65535)));
         end
      end else if (r == 9) begin
         offer_noise();
      end
   endtask

   task automatic write_setting(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Settings change only once every expected event is out and the pipeline is empty.
   task automatic apply_setting(input int unsigned hold_len, input int unsigned floor_vel);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_setting(CSR_MIN_NOTE_SAMPLES, CSR_DATA_W'(hold_len));
      write_setting(CSR_MIN_VELOCITY, CSR_DATA_W'(floor_vel));
      hold_now = hold_len;
      settings_used++;
   endtask

   initial begin
      int unsigned phase_start;
      int unsigned hold_len;
      int unsigned floor_vel;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_MIN_NOTE_SAMPLES;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.detected = 1'b0;
      req_bus.note_number = '0;
      req_bus.detect_offset = '0;
      req_bus.block_length = '0;
      req_bus.rms_level = '0;
      rsp_bus.ready = 1'b0;
      calm_send = 1'b0;
      calm_recv = 1'b0;
      hold_now = MNS_RESET;
      settings_used = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings.
      offer(1'b1, 7'd0, 12'd0, 13'd1, 16'd0);
      offer(1'b1, 7'd0, 12'd4095, 13'd8191, 16'd65535);
      offer(1'b0, 7'd127, 12'd4095, 13'd0, 16'd65535);
      offer(1'b0, 7'd0, 12'd0, 13'd8191, 16'd0);
      offer(1'b1, 7'd127, 12'd100, 13'd4096, 16'd32768);
      offer(1'b1, 7'd127, 12'd0, 13'd16, 16'd32768);
      offer(1'b1, 7'd64, 12'd4095, 13'd1, 16'd1000);
      offer(1'b1, 7'd64, 12'd0, 13'd100, 16'd1000);
      offer(1'b1, 7'd64, 12'd4000, 13'd100, 16'd1000);
      offer(1'b1, 7'd64, 12'd4095, 13'd50, 16'd100);
      offer(1'b1, 7'd64, 12'd10, 13'd50, 16'd40000);
      offer(1'b0, 7'd0, 12'd0, 13'd48, 16'd0);
      offer(1'b0, 7'd0, 12'd0, 13'd1, 16'd0);
      offer(1'b0, 7'd0, 12'd0, 13'd10, 16'd0);
      offer(1'b1, 7'd0, 12'd0, 13'd20, 16'd0);
      offer(1'b1, 7'd0, 12'd2048, 13'd2048, 16'd32767);
      offer(1'b1, 7'd85, 12'd2730, 13'd2730, 16'd43690);
      offer(1'b1, 7'd42, 12'd1365, 13'd5461, 16'd21845);
      offer(1'b1, 7'd42, 12'd4095, 13'd4096, 16'd65535);
      offer(1'b0, 7'd42, 12'd0, 13'd4096, 16'd0);
      offer(1'b1, 7'd1, 12'd0, 13'd1, 16'd1);
      offer(1'b1, 7'd2, 12'd0, 13'd1, 16'd1);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               hold_len = 0;
               floor_vel = 0;
            end
            1: begin
               hold_len = 65535;
               floor_vel = 64;
            end
            2: begin
               hold_len = $urandom_range(1, 400);
               floor_vel = $urandom_range(0, 64);
            end
            3: begin
               hold_len = 4000;
               floor_vel = 1;
            end
            default: begin
               hold_len = 48;
               floor_vel = 32;
            end
         endcase
         apply_setting(hold_len, floor_vel);
         if (p == 0) begin
            // Events come often here, so a long receiver stall backs the block up.
            squeeze_ask++;
            steady_words = SQUEEZE_WORDS;
         end
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) play_phrase();
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d block words through %0d hold and velocity settings.", words_sent,
               settings_used);
      $display("Compared %0d note-on and %0d note-off events.", note_on_count, note_off_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("pitch_to_note_event_gate_core: match");
      end else begin
         $display("pitch_to_note_event_gate_core: mismatch");
      end
      $finish;
   end

endmodule
